// ===== rtl/core/polyline_uniform_resampler_defines.svh =====
// assertion macros for the polyline resampler checker
// no dependencies; clock is i_clk, reset i_rst_n in the using scope
`ifndef POLYLINE_UNIFORM_RESAMPLER_DEFINES_SVH
`define POLYLINE_UNIFORM_RESAMPLER_DEFINES_SVH

// checked only outside reset
`define PRS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// checked at every edge, reset included
`define PRS_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");

`endif

// ===== rtl/core/prs_pkg.sv =====
// shared types and constants of the polyline resampler
// no dependencies
`timescale 1ns / 1ps

package prs_pkg;

    localparam int X_W       = 24;
    localparam int Y_W       = 16;
    localparam int D_W       = 25;
    localparam int RATIO_W   = 17;
    localparam int MAX_EMITS = 63;
    localparam int CNT_W     = 6;
    localparam int N_W       = 7;
    localparam int BUF_AW    = 6;

    localparam logic [X_W-1:0] SPACING_RESET = 24'd256;
    localparam logic [D_W-1:0] DMAX          = {D_W{1'b1}};

    typedef struct packed {
        logic           first;
        logic           last;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
    } t_item;

    typedef struct packed {
        logic              en;
        logic [BUF_AW-1:0] addr;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
    } t_wr;

    typedef struct packed {
        logic           valid;
        logic [N_W-1:0] n;
        logic           trunc;
        logic           mark_last;
    } t_commit;

endpackage

// ===== rtl/core/polyline_uniform_resampler.sv =====
// top level of the polyline uniform resampler
// depends on prs_pkg, prs_front, prs_engine, prs_outbuf
// - input channel (i_in_valid / o_in_ready) takes one vertex per transfer,
//   i_in_last marks the final vertex of a path
// - output channel (o_out_valid / i_out_ready) gives the resampled points;
//   o_out_last marks the final point, o_truncated flags every point of a
//   step whose segment hit the cap of 63 interpolated points
// - config channel (i_cfg_valid / o_cfg_ready) writes the spacing, always
//   ready; write it only while the block is idle
// - a two-entry queue sits behind the input, so vertices are taken while
//   the engine walks a segment or points wait at the output
// - per segment: the length comes from a 25-step square root, then each
//   interpolated point takes a square root, a 17-step divider and two
//   multiplies; a first vertex is written to the buffer straight from idle
// - the points of a step are buffered and leave once the step is done;
//   each point passes a read, a load and a hold state before the next
// - a stalled receiver holds the current point; the engine waits for the
//   buffer to drain before it starts the next vertex
// - reset empties the queue and buffer, ends any open path and sets the
//   spacing to 1.0 (256)
`timescale 1ns / 1ps

module polyline_uniform_resampler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_spacing,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [23:0] i_in_x,
    input  logic [15:0] i_in_y,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [23:0] o_out_x,
    output logic [15:0] o_out_y,
    output logic        o_out_last,
    output logic        o_truncated
);

    logic [23:0]      r_spacing;
    prs_pkg::t_item   item;
    logic             item_valid, item_pop, buf_busy;
    prs_pkg::t_wr     wr;
    prs_pkg::t_commit commit;

    // spacing register, taken on every config transfer
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= prs_pkg::SPACING_RESET;
        end else if (i_cfg_valid) begin
            r_spacing <= i_cfg_spacing;
        end
    end

    // front: vertex transfer and first / segment classification
    prs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_x       (i_in_x),
        .i_in_y       (i_in_y),
        .i_in_last    (i_in_last),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_pop   (item_pop)
    );

    // back: walk of one segment at a time
    prs_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_pop   (item_pop),
        .i_spacing    (r_spacing),
        .i_buf_busy   (buf_busy),
        .o_wr         (wr),
        .o_commit     (commit)
    );

    // result buffer and output register
    prs_outbuf u_outbuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (wr),
        .i_commit     (commit),
        .o_busy       (buf_busy),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_out_last   (o_out_last),
        .o_truncated  (o_truncated)
    );

endmodule

// ===== rtl/core/prs_front.sv =====
// front part: input transfer, path tracking and the two-entry item queue
// depends on prs_pkg
`timescale 1ns / 1ps

module prs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [23:0]    i_in_x,
    input  logic [15:0]    i_in_y,
    input  logic           i_in_last,
    output prs_pkg::t_item o_item,
    output logic           o_item_valid,
    input  logic           i_item_pop
);

    prs_pkg::t_item r_q [2];
    logic           r_wp, n_wp, r_rp, n_rp;
    logic [1:0]     r_cnt, n_cnt;
    logic           r_started, n_started;
    logic           acc, push;

    assign o_in_ready   = (r_cnt != 2'd2);
    assign acc          = i_in_valid && o_in_ready;
    // a lone final vertex outside a path has no effect at all
    assign push         = acc && (r_started || !i_in_last);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    always_comb begin
        n_started = r_started;
        if (acc) begin
            if (!r_started) n_started = !i_in_last;
            else if (i_in_last) n_started = 1'b0;
        end
        n_wp  = push ? !r_wp : r_wp;
        n_rp  = i_item_pop ? !r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, i_item_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_wp      <= 1'b0;
            r_rp      <= 1'b0;
            r_cnt     <= 2'd0;
        end else begin
            r_started <= n_started;
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{first: !r_started, last: i_in_last, x: i_in_x, y: i_in_y};
        end
    end

endmodule

// ===== rtl/core/prs_engine.sv =====
// back part: segment walk with iterative square root and divider
// depends on prs_pkg
`timescale 1ns / 1ps

module prs_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  prs_pkg::t_item      i_item,
    input  logic                i_item_valid,
    output logic                o_item_pop,
    input  logic [23:0]         i_spacing,
    input  logic                i_buf_busy,
    output prs_pkg::t_wr        o_wr,
    output prs_pkg::t_commit    o_commit
);

    localparam logic [3:0] E_IDLE = 4'd0;
    localparam logic [3:0] E_DX   = 4'd1;
    localparam logic [3:0] E_DY   = 4'd2;
    localparam logic [3:0] E_SQ   = 4'd3;
    localparam logic [3:0] E_CHK  = 4'd4;
    localparam logic [3:0] E_DIV  = 4'd5;
    localparam logic [3:0] E_MX   = 4'd6;
    localparam logic [3:0] E_AX   = 4'd7;
    localparam logic [3:0] E_MY   = 4'd8;
    localparam logic [3:0] E_AY   = 4'd9;
    localparam logic [3:0] E_END  = 4'd10;

    logic [3:0]  r_st, n_st;
    logic [23:0] r_px, r_cx, r_emx, r_nx;
    logic [15:0] r_py, r_cy, r_emy;
    logic        r_last;
    logic [24:0] r_carry, r_acc, r_seg;
    logic [5:0]  r_cnt;
    logic [6:0]  r_n;
    logic [48:0] r_sq;
    logic [49:0] r_rad;
    logic [24:0] r_root;
    logic [27:0] r_rem;
    logic [4:0]  r_it;
    logic [25:0] r_dr;
    logic [16:0] r_dsh, r_q;
    logic [40:0] r_prod;

    logic [23:0] dxabs;
    logic [15:0] dyabs;
    logic        x_up, y_up;
    logic [27:0] rem_sh, trial;
    logic [25:0] dv_t, sum;
    logic [23:0] rem_sp;
    logic [41:0] prod_rnd;
    logic [23:0] lerp_x;
    logic [15:0] lerp_y;
    logic        due, ep_diff;

    assign x_up     = (r_cx >= r_px);
    assign y_up     = (r_cy >= r_py);
    assign dxabs    = x_up ? r_cx - r_px : r_px - r_cx;
    assign dyabs    = y_up ? r_cy - r_py : r_py - r_cy;
    assign rem_sh   = {r_rem[25:0], r_rad[49:48]};
    assign trial    = {1'b0, r_root, 2'b01};
    assign dv_t     = {r_dr[24:0], r_dsh[16]};
    assign sum      = {1'b0, r_acc} + {1'b0, r_seg};
    assign due      = (i_spacing != 24'd0) && (sum >= {2'b00, i_spacing});
    assign rem_sp   = ({1'b0, i_spacing} > r_acc) ? i_spacing - r_acc[23:0] : 24'd0;
    assign prod_rnd = {1'b0, r_prod} + 42'd65535;
    // floor toward minus infinity on a falling axis
    assign lerp_x   = x_up ? r_px + r_prod[39:16] : r_px - prod_rnd[39:16];
    assign lerp_y   = y_up ? r_py + r_prod[31:16] : r_py - prod_rnd[31:16];
    assign ep_diff  = (r_emx != r_cx) || (r_emy != r_cy);

    assign o_item_pop = (r_st == E_IDLE) && i_item_valid && !i_buf_busy;

    always_comb begin
        n_st     = r_st;
        o_wr     = '{en: 1'b0, addr: r_n[5:0], x: r_nx, y: lerp_y};
        o_commit = '{valid: 1'b0, n: r_n, trunc: 1'b0, mark_last: 1'b0};
        case (r_st)
            E_IDLE: begin
                if (o_item_pop) begin
                    if (i_item.first) begin
                        o_wr     = '{en: 1'b1, addr: '0, x: i_item.x, y: i_item.y};
                        o_commit = '{valid: 1'b1, n: 7'd1, trunc: 1'b0, mark_last: 1'b0};
                    end else begin
                        n_st = E_DX;
                    end
                end
            end
            E_DX:  n_st = E_DY;
            E_DY:  n_st = E_SQ;
            E_SQ:  if (r_it == 5'd24) n_st = E_CHK;
            E_CHK: begin
                if (!due || r_cnt == 6'(prs_pkg::MAX_EMITS)) n_st = E_END;
                else if (r_seg == 25'd0) n_st = E_MX;
                else n_st = E_DIV;
            end
            E_DIV: if (r_it == 5'd16) n_st = E_MX;
            E_MX:  n_st = E_AX;
            E_AX:  n_st = E_MY;
            E_MY:  n_st = E_AY;
            E_AY: begin
                o_wr.en = 1'b1;
                n_st    = E_DX;
            end
            E_END: begin
                o_commit.valid = 1'b1;
                o_commit.trunc = due;
                n_st           = E_IDLE;
                if (r_last) begin
                    o_commit.mark_last = 1'b1;
                    if (ep_diff) begin
                        o_wr       = '{en: 1'b1, addr: r_n[5:0], x: r_cx, y: r_cy};
                        o_commit.n = r_n + 7'd1;
                    end
                end
            end
            default: n_st = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= E_IDLE;
            r_carry <= '0;
            r_emx   <= '0;
            r_emy   <= '0;
            r_px    <= '0;
            r_py    <= '0;
        end else begin
            r_st <= n_st;
            case (r_st)
                E_IDLE: begin
                    if (o_item_pop) begin
                        r_cx   <= i_item.x;
                        r_cy   <= i_item.y;
                        r_last <= i_item.last;
                        r_acc  <= r_carry;
                        r_cnt  <= '0;
                        r_n    <= '0;
                        if (i_item.first) begin
                            r_px    <= i_item.x;
                            r_py    <= i_item.y;
                            r_emx   <= i_item.x;
                            r_emy   <= i_item.y;
                            r_carry <= '0;
                        end
                    end
                end
                E_DX: r_sq <= {25'd0, dxabs} * {25'd0, dxabs};
                E_DY: begin
                    r_rad  <= {1'b0, r_sq + {17'd0, 32'(dyabs) * 32'(dyabs)}};
                    r_root <= '0;
                    r_rem  <= '0;
                    r_it   <= '0;
                end
                E_SQ: begin
                    r_rad <= {r_rad[47:0], 2'b00};
                    r_it  <= r_it + 5'd1;
                    if (rem_sh >= trial) begin
                        r_rem  <= rem_sh - trial;
                        r_root <= {r_root[23:0], 1'b1};
                    end else begin
                        r_rem  <= rem_sh;
                        r_root <= {r_root[23:0], 1'b0};
                    end
                    if (r_it == 5'd24) r_seg <= (rem_sh >= trial) ? {r_root[23:0], 1'b1}
                                                                  : {r_root[23:0], 1'b0};
                end
                E_CHK: begin
                    r_dr  <= {3'd0, rem_sp[23:1]};
                    r_dsh <= {rem_sp[0], 16'd0};
                    r_q   <= '0;
                    r_it  <= '0;
                end
                E_DIV: begin
                    r_dsh <= {r_dsh[15:0], 1'b0};
                    r_it  <= r_it + 5'd1;
                    if (dv_t >= {1'b0, r_seg}) begin
                        r_dr <= dv_t - {1'b0, r_seg};
                        r_q  <= {r_q[15:0], 1'b1};
                    end else begin
                        r_dr <= dv_t;
                        r_q  <= {r_q[15:0], 1'b0};
                    end
                end
                E_MX: r_prod <= r_q * dxabs;
                E_AX: r_nx   <= lerp_x;
                E_MY: r_prod <= r_q * {8'd0, dyabs};
                E_AY: begin
                    r_px  <= r_nx;
                    r_py  <= lerp_y;
                    r_emx <= r_nx;
                    r_emy <= lerp_y;
                    r_n   <= r_n + 7'd1;
                    r_cnt <= r_cnt + 6'd1;
                    r_acc <= '0;
                end
                E_END: begin
                    r_px <= r_cx;
                    r_py <= r_cy;
                    if (r_last) begin
                        r_carry <= '0;
                        if (ep_diff) begin
                            r_emx <= r_cx;
                            r_emy <= r_cy;
                        end
                    end else begin
                        r_carry <= sum[25] ? prs_pkg::DMAX : sum[24:0];
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/prs_outbuf.sv =====
// result buffer of one step and its drain onto the output channel
// depends on prs_pkg
`timescale 1ns / 1ps

module prs_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  prs_pkg::t_wr     i_wr,
    input  prs_pkg::t_commit i_commit,
    output logic             o_busy,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [23:0]      o_out_x,
    output logic [15:0]      o_out_y,
    output logic             o_out_last,
    output logic             o_truncated
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_READ = 2'd1;
    localparam logic [1:0] D_LOAD = 2'd2;
    localparam logic [1:0] D_HOLD = 2'd3;

    logic [39:0] r_mem [64];
    logic [39:0] r_rdata, r_out;
    logic [1:0]  r_st, n_st;
    logic [5:0]  r_idx, n_idx;
    logic [6:0]  r_cnt;
    logic        r_trunc, r_mark;
    logic        at_end;

    assign at_end      = ({1'b0, r_idx} == r_cnt - 7'd1);
    assign o_busy      = (r_st != D_IDLE);
    assign o_out_valid = (r_st == D_HOLD);
    assign o_out_x     = r_out[39:16];
    assign o_out_y     = r_out[15:0];
    assign o_out_last  = r_mark && at_end;
    assign o_truncated = r_trunc;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) r_mem[i_wr.addr] <= {i_wr.x, i_wr.y};
        r_rdata <= r_mem[r_idx];
    end

    always_comb begin
        n_st  = r_st;
        n_idx = r_idx;
        case (r_st)
            D_IDLE: begin
                if (i_commit.valid && i_commit.n != 7'd0) begin
                    n_st  = D_READ;
                    n_idx = '0;
                end
            end
            D_READ: n_st = D_LOAD;
            D_LOAD: n_st = D_HOLD;
            D_HOLD: begin
                if (i_out_ready) begin
                    if (at_end) begin
                        n_st = D_IDLE;
                    end else begin
                        n_st  = D_READ;
                        n_idx = r_idx + 6'd1;
                    end
                end
            end
            default: n_st = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= D_IDLE;
            r_idx <= '0;
        end else begin
            r_st  <= n_st;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == D_IDLE && i_commit.valid) begin
            r_cnt   <= i_commit.n;
            r_trunc <= i_commit.trunc;
            r_mark  <= i_commit.mark_last;
        end
        if (r_st == D_LOAD) r_out <= r_rdata;
    end

endmodule

// ===== rtl/core/prs_checker.sv =====
// port-level checks of the polyline resampler, bound to the top level
// depends on polyline_uniform_resampler_defines.svh
`timescale 1ns / 1ps
`include "polyline_uniform_resampler_defines.svh"

module prs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [23:0] o_out_x,
    input logic [15:0] o_out_y,
    input logic        o_out_last,
    input logic        o_truncated
);

    `PRS_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid)
    `PRS_ASSERT(a_out_stable, o_out_valid && !i_out_ready |=> $stable(o_out_x)
        && $stable(o_out_y) && $stable(o_out_last) && $stable(o_truncated))
    `PRS_ASSERT_ALWAYS(a_rst_out_idle, !i_rst_n |=> !o_out_valid)
    `PRS_ASSERT_ALWAYS(a_rst_in_ready, !i_rst_n |=> o_in_ready)

endmodule

bind polyline_uniform_resampler prs_checker u_prs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_x     (o_out_x),
    .o_out_y     (o_out_y),
    .o_out_last  (o_out_last),
    .o_truncated (o_truncated)
);
